// File: design/vfcm_pkg.sv
`timescale 1ns / 1ps

package vfcm_pkg;

  localparam int CHUNK_X = 16;
  localparam int CHUNK_Y = 16;
  localparam int CHUNK_Z = 16;

  localparam int STORE_SIZE = CHUNK_X * CHUNK_Y * CHUNK_Z;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  // Address strides between neighboring blocks along each axis.
  localparam int OFF_X = CHUNK_Y * CHUNK_Z;
  localparam int OFF_Y = CHUNK_Z;
  localparam int OFF_Z = 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MESH  = 1'b1;

  localparam logic [1:0] REG_AIR   = 2'd0;
  localparam logic [1:0] REG_DIRT  = 2'd1;
  localparam logic [1:0] REG_GRASS = 2'd2;

  localparam logic [7:0] AIR_RESET   = 8'd0;
  localparam logic [7:0] DIRT_RESET  = 8'd1;
  localparam logic [7:0] GRASS_RESET = 8'd2;

  typedef struct packed {
    logic       command;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] block_type;
  } req_t;

  typedef struct packed {
    logic [4:0] vert_x;
    logic [4:0] vert_y;
    logic [4:0] vert_z;
    logic [6:0] tex_u;
    logic [5:0] tex_v;
    logic [7:0] texture_id;
    logic       last_vertex;
  } vtx_t;

  typedef struct packed {
    logic xlo;
    logic xhi;
    logic ylo;
    logic yhi;
    logic zlo;
    logic zhi;
  } border_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        pos_x;
    logic [3:0]        pos_y;
    logic [3:0]        pos_z;
    logic [7:0]        block_type;
    border_t           brd;
  } qent_t;

  typedef struct packed {
    logic [7:0] air;
    logic [7:0] dirt;
    logic [7:0] grass;
  } cfg_t;

  typedef struct packed {
    logic       dx;
    logic       dy;
    logic       dz;
    logic [6:0] u;
    logic [5:0] v;
  } corner_t;

  // Corner offsets and atlas coordinates, faces left, right, front, back, top, bottom.
  localparam corner_t [0:5][0:5] FACE_TBL = '{
    '{'{1'b0, 1'b0, 1'b1, 7'd0,  6'd0},  '{1'b0, 1'b0, 1'b0, 7'd32, 6'd0},
      '{1'b0, 1'b1, 1'b0, 7'd32, 6'd32}, '{1'b0, 1'b1, 1'b0, 7'd32, 6'd32},
      '{1'b0, 1'b1, 1'b1, 7'd0,  6'd32}, '{1'b0, 1'b0, 1'b1, 7'd0,  6'd0}},
    '{'{1'b1, 1'b0, 1'b1, 7'd0,  6'd0},  '{1'b1, 1'b0, 1'b0, 7'd32, 6'd0},
      '{1'b1, 1'b1, 1'b0, 7'd32, 6'd32}, '{1'b1, 1'b1, 1'b0, 7'd32, 6'd32},
      '{1'b1, 1'b1, 1'b1, 7'd0,  6'd32}, '{1'b1, 1'b0, 1'b1, 7'd0,  6'd0}},
    '{'{1'b0, 1'b0, 1'b0, 7'd0,  6'd0},  '{1'b1, 1'b0, 1'b0, 7'd32, 6'd0},
      '{1'b1, 1'b1, 1'b0, 7'd32, 6'd32}, '{1'b1, 1'b1, 1'b0, 7'd32, 6'd32},
      '{1'b0, 1'b1, 1'b0, 7'd0,  6'd32}, '{1'b0, 1'b0, 1'b0, 7'd0,  6'd0}},
    '{'{1'b0, 1'b0, 1'b1, 7'd0,  6'd0},  '{1'b1, 1'b0, 1'b1, 7'd32, 6'd0},
      '{1'b1, 1'b1, 1'b1, 7'd32, 6'd32}, '{1'b1, 1'b1, 1'b1, 7'd32, 6'd32},
      '{1'b0, 1'b1, 1'b1, 7'd0,  6'd32}, '{1'b0, 1'b0, 1'b1, 7'd0,  6'd0}},
    '{'{1'b0, 1'b1, 1'b0, 7'd64, 6'd0},  '{1'b1, 1'b1, 1'b0, 7'd96, 6'd0},
      '{1'b1, 1'b1, 1'b1, 7'd96, 6'd32}, '{1'b1, 1'b1, 1'b1, 7'd96, 6'd32},
      '{1'b0, 1'b1, 1'b1, 7'd64, 6'd32}, '{1'b0, 1'b1, 1'b0, 7'd64, 6'd0}},
    '{'{1'b0, 1'b0, 1'b0, 7'd32, 6'd0},  '{1'b1, 1'b0, 1'b0, 7'd64, 6'd0},
      '{1'b1, 1'b0, 1'b1, 7'd64, 6'd32}, '{1'b1, 1'b0, 1'b1, 7'd64, 6'd32},
      '{1'b0, 1'b0, 1'b1, 7'd32, 6'd32}, '{1'b0, 1'b0, 1'b0, 7'd32, 6'd0}}
  };

endpackage

// File: design/vfcm_req_if.sv
`timescale 1ns / 1ps

interface vfcm_req_if;
  logic            valid;
  logic            ready;
  vfcm_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/vfcm_vtx_if.sv
`timescale 1ns / 1ps

interface vfcm_vtx_if;
  logic            valid;
  logic            ready;
  vfcm_pkg::vtx_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/vfcm_front.sv
`timescale 1ns / 1ps

module vfcm_front (
  vfcm_req_if.sink        req_i,
  input  logic            full_i,
  output logic            push_o,
  output vfcm_pkg::qent_t push_data_o
);

  logic in_range;
  int   xi, yi, zi;

  assign xi = int'(req_i.data.pos_x);
  assign yi = int'(req_i.data.pos_y);
  assign zi = int'(req_i.data.pos_z);

  assign in_range = (xi < vfcm_pkg::CHUNK_X) && (yi < vfcm_pkg::CHUNK_Y) &&
                    (zi < vfcm_pkg::CHUNK_Z);

  assign req_i.ready = !full_i;
  // Requests outside the chunk are taken and dropped here.
  assign push_o      = req_i.valid && !full_i && in_range;

  always_comb begin
    push_data_o.command    = req_i.data.command;
    push_data_o.addr       = vfcm_pkg::ADDR_W'((xi * vfcm_pkg::CHUNK_Y + yi) *
                                               vfcm_pkg::CHUNK_Z + zi);
    push_data_o.pos_x      = req_i.data.pos_x;
    push_data_o.pos_y      = req_i.data.pos_y;
    push_data_o.pos_z      = req_i.data.pos_z;
    push_data_o.block_type = req_i.data.block_type;
    push_data_o.brd.xlo    = (xi == 0);
    push_data_o.brd.xhi    = (xi + 1 == vfcm_pkg::CHUNK_X);
    push_data_o.brd.ylo    = (yi == 0);
    push_data_o.brd.yhi    = (yi + 1 == vfcm_pkg::CHUNK_Y);
    push_data_o.brd.zlo    = (zi == 0);
    push_data_o.brd.zhi    = (zi + 1 == vfcm_pkg::CHUNK_Z);
  end

endmodule

// File: design/vfcm_fifo.sv
`timescale 1ns / 1ps

module vfcm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vfcm_pkg::qent_t push_data_i,
  input  logic            pop_i,
  output vfcm_pkg::qent_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam logic [vfcm_pkg::QPTR_W-1:0] PTR_LAST = vfcm_pkg::QPTR_W'(vfcm_pkg::QDEPTH - 1);

  vfcm_pkg::qent_t                ent_q [vfcm_pkg::QDEPTH];
  logic [vfcm_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [vfcm_pkg::QCNT_W-1:0]    count_q;
  logic                           do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == vfcm_pkg::QCNT_W'(vfcm_pkg::QDEPTH));
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: design/vfcm_back.sv
`timescale 1ns / 1ps

module vfcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vfcm_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  vfcm_pkg::qent_t head_i,
  output logic            pop_o,
  vfcm_vtx_if.source      vtx_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_EVAL,
    S_EMIT
  } state_e;

  // Read order: center, then the neighbors in face order.
  localparam logic [2:0] RD_CENTER = 3'd0;
  localparam logic [2:0] RD_LEFT   = 3'd1;
  localparam logic [2:0] RD_RIGHT  = 3'd2;
  localparam logic [2:0] RD_FRONT  = 3'd3;
  localparam logic [2:0] RD_BACK   = 3'd4;
  localparam logic [2:0] RD_TOP    = 3'd5;
  localparam logic [2:0] RD_BOTTOM = 3'd6;
  localparam logic [2:0] VTX_LAST  = 3'd5;

  localparam logic [vfcm_pkg::ADDR_W-1:0] STEP_X = vfcm_pkg::ADDR_W'(vfcm_pkg::OFF_X);
  localparam logic [vfcm_pkg::ADDR_W-1:0] STEP_Y = vfcm_pkg::ADDR_W'(vfcm_pkg::OFF_Y);
  localparam logic [vfcm_pkg::ADDR_W-1:0] STEP_Z = vfcm_pkg::ADDR_W'(vfcm_pkg::OFF_Z);

  function automatic logic [2:0] low_idx(input logic [5:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = 5; i >= 0; i--) begin
      if (m[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  state_e                      state_q;
  vfcm_pkg::qent_t             ent_q;
  logic [2:0]                  rd_cnt_q, ridx_q;
  logic                        rv_q;
  logic [6:0]                  air_q;
  logic [7:0]                  tex_q;
  logic [5:0]                  vis_q;
  logic [2:0]                  face_q, vtx_q;
  logic                        out_valid_q;
  vfcm_pkg::vtx_t              out_q;

  logic [7:0]                  mem_q [vfcm_pkg::STORE_SIZE];
  logic [7:0]                  rdata_q;
  logic [vfcm_pkg::ADDR_W-1:0] raddr;
  logic                        rd_en, mem_we;

  logic [5:0]                  vis_d, higher;
  logic [7:0]                  tex_d;
  logic                        more, slot_free, emit;
  vfcm_pkg::corner_t           corner;

  assign pop_o  = (state_q == S_IDLE) && !empty_i;
  assign mem_we = pop_o && (head_i.command == vfcm_pkg::CMD_WRITE);
  assign rd_en  = (state_q == S_READ);

  always_comb begin
    unique case (rd_cnt_q)
      RD_CENTER: raddr = ent_q.addr;
      RD_LEFT:   raddr = ent_q.brd.xlo ? ent_q.addr : ent_q.addr - STEP_X;
      RD_RIGHT:  raddr = ent_q.brd.xhi ? ent_q.addr : ent_q.addr + STEP_X;
      RD_FRONT:  raddr = ent_q.brd.zlo ? ent_q.addr : ent_q.addr - STEP_Z;
      RD_BACK:   raddr = ent_q.brd.zhi ? ent_q.addr : ent_q.addr + STEP_Z;
      RD_TOP:    raddr = ent_q.brd.yhi ? ent_q.addr : ent_q.addr + STEP_Y;
      RD_BOTTOM: raddr = ent_q.brd.ylo ? ent_q.addr : ent_q.addr - STEP_Y;
      default:   raddr = ent_q.addr;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_i.addr] <= head_i.block_type;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    vis_d[0] = ent_q.brd.xlo || air_q[RD_LEFT];
    vis_d[1] = ent_q.brd.xhi || air_q[RD_RIGHT];
    vis_d[2] = ent_q.brd.zlo || air_q[RD_FRONT];
    vis_d[3] = ent_q.brd.zhi || air_q[RD_BACK];
    vis_d[4] = ent_q.brd.yhi || air_q[RD_TOP];
    vis_d[5] = ent_q.brd.ylo || air_q[RD_BOTTOM];
    // Grass covered by a solid block is drawn with the dirt texture.
    tex_d = (tex_q == cfg_i.grass && !ent_q.brd.yhi && !air_q[RD_TOP]) ? cfg_i.dirt : tex_q;
    for (int i = 0; i < 6; i++) begin
      higher[i] = vis_q[i] && (3'(i) > face_q);
    end
    more      = |higher;
    corner    = vfcm_pkg::FACE_TBL[face_q][vtx_q];
    slot_free = !out_valid_q || vtx_o.ready;
    emit      = (state_q == S_EMIT) && slot_free;
  end

  assign vtx_o.valid = out_valid_q;
  assign vtx_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ent_q       <= '0;
      rd_cnt_q    <= '0;
      ridx_q      <= '0;
      rv_q        <= 1'b0;
      air_q       <= '0;
      tex_q       <= '0;
      vis_q       <= '0;
      face_q      <= '0;
      vtx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rv_q   <= rd_en;
      ridx_q <= rd_cnt_q;
      if (rv_q) begin
        air_q[ridx_q] <= (rdata_q == cfg_i.air);
        if (ridx_q == RD_CENTER) begin
          tex_q <= rdata_q;
        end
      end

      if (emit) begin
        out_valid_q       <= 1'b1;
        out_q.vert_x      <= {1'b0, ent_q.pos_x} + {4'b0, corner.dx};
        out_q.vert_y      <= {1'b0, ent_q.pos_y} + {4'b0, corner.dy};
        out_q.vert_z      <= {1'b0, ent_q.pos_z} + {4'b0, corner.dz};
        out_q.tex_u       <= corner.u;
        out_q.tex_v       <= corner.v;
        out_q.texture_id  <= tex_q;
        out_q.last_vertex <= (vtx_q == VTX_LAST) && !more;
      end else if (vtx_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (!empty_i && head_i.command == vfcm_pkg::CMD_MESH) begin
            ent_q    <= head_i;
            rd_cnt_q <= RD_CENTER;
            state_q  <= S_READ;
          end
        end
        S_READ: begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == RD_BOTTOM) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          // An air block or a fully enclosed block gives no vertices.
          if (air_q[RD_CENTER] || vis_d == '0) begin
            state_q <= S_IDLE;
          end else begin
            vis_q   <= vis_d;
            tex_q   <= tex_d;
            face_q  <= low_idx(vis_d);
            vtx_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (vtx_q == VTX_LAST) begin
              vtx_q <= '0;
              if (more) begin
                face_q <= low_idx(higher);
              end else begin
                state_q <= S_IDLE;
              end
            end else begin
              vtx_q <= vtx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/voxel_face_cull_mesher.sv
`timescale 1ns / 1ps

// Voxel mesher for one chunk of block type codes.
// Requests arrive on req_i (valid/ready). A write request stores block_type at
// pos_x/pos_y/pos_z; a mesh request emits the vertices of the visible faces of
// that block on vtx_o, six per face in the order left, right, front, back,
// top, bottom, with last_vertex set on the final one. Requests outside the
// chunk, air blocks and fully enclosed blocks give no vertices.
// The air, dirt and grass codes are set through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must do so only while no request is in flight; the block does not
// enforce it. Reset loads 0, 1 and 2. Requests enter a two-entry queue, so
// req_i stays ready while the mesh engine is busy until the queue fills. A
// write is stored in the block memory as the engine pops it. A mesh request
// reads seven store entries through the single read port of the block memory,
// one per cycle, then evaluates the visible faces and emits one vertex per
// cycle while vtx_o is ready. If vtx_o stalls, the engine holds its place and
// the output register keeps its vertex. The store content is not cleared at
// reset; every entry must be written before a mesh request reads it.
module voxel_face_cull_mesher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  vfcm_req_if.sink   req_i,
  vfcm_vtx_if.source vtx_o
);

  vfcm_pkg::cfg_t  cfg_q;
  vfcm_pkg::qent_t push_data, head;
  logic            push, pop, empty, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.air   <= vfcm_pkg::AIR_RESET;
      cfg_q.dirt  <= vfcm_pkg::DIRT_RESET;
      cfg_q.grass <= vfcm_pkg::GRASS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vfcm_pkg::REG_AIR:   cfg_q.air   <= cfg_data_i;
        vfcm_pkg::REG_DIRT:  cfg_q.dirt  <= cfg_data_i;
        vfcm_pkg::REG_GRASS: cfg_q.grass <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vfcm_front u_front (
    .req_i       (req_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  vfcm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  vfcm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .vtx_o   (vtx_o)
  );

endmodule

// File: tb/vfcm_vertex_checker.sv
`timescale 1ns / 1ps

module vfcm_vertex_checker
  import vfcm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  vfcm_req_if        req_i,
  vfcm_vtx_if        vtx_i,
  output int         pending_o,
  output int         fail_count_o
);

  typedef enum int {
    FACE_LEFT,
    FACE_RIGHT,
    FACE_FRONT,
    FACE_BACK,
    FACE_TOP,
    FACE_BOTTOM
  } face_e;

  // Per face, six corners packed as {dx, dy, dz, u / 32 (2 bits), v / 32}.
  localparam bit [0:35][5:0] CORNER_TBL = {
    6'b001000, 6'b000010, 6'b010011, 6'b010011, 6'b011001, 6'b001000,
    6'b101000, 6'b100010, 6'b110011, 6'b110011, 6'b111001, 6'b101000,
    6'b000000, 6'b100010, 6'b110011, 6'b110011, 6'b010001, 6'b000000,
    6'b001000, 6'b101010, 6'b111011, 6'b111011, 6'b011001, 6'b001000,
    6'b010100, 6'b110110, 6'b111111, 6'b111111, 6'b011101, 6'b010100,
    6'b000010, 6'b100100, 6'b101101, 6'b101101, 6'b001011, 6'b000010
  };

  logic [7:0] chunk_types [STORE_SIZE];
  logic [7:0] air_code_q;
  logic [7:0] dirt_code_q;
  logic [7:0] grass_code_q;
  vtx_t       vertex_fifo [$];
  int         fails = 0;

  function automatic int cell_of(input int x, input int y, input int z);
    return (x * CHUNK_Y + y) * CHUNK_Z + z;
  endfunction

  function automatic bit is_open(input int x, input int y, input int z);
    return chunk_types[cell_of(x, y, z)] == air_code_q;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Queues the vertices of every exposed face of the named block.
  function automatic void predict_mesh(input req_t r);
    int         x;
    int         y;
    int         z;
    int         total;
    int         idx;
    bit [5:0]   exposed;
    bit [5:0]   corner;
    logic [7:0] tex;
    vtx_t       v;
    x = r.pos_x;
    y = r.pos_y;
    z = r.pos_z;
    tex = chunk_types[cell_of(x, y, z)];
    if (tex == air_code_q) return;
    // Grass covered by a solid block shows the dirt texture.
    if (tex == grass_code_q && y + 1 < CHUNK_Y && !is_open(x, y + 1, z)) tex = dirt_code_q;
    exposed[FACE_LEFT]   = (x == 0) || is_open(x - 1, y, z);
    exposed[FACE_RIGHT]  = (x + 1 == CHUNK_X) || is_open(x + 1, y, z);
    exposed[FACE_FRONT]  = (z == 0) || is_open(x, y, z - 1);
    exposed[FACE_BACK]   = (z + 1 == CHUNK_Z) || is_open(x, y, z + 1);
    exposed[FACE_TOP]    = (y + 1 == CHUNK_Y) || is_open(x, y + 1, z);
    exposed[FACE_BOTTOM] = (y == 0) || is_open(x, y - 1, z);
    total = 6 * $countones(exposed);
    idx = 0;
    for (int f = FACE_LEFT; f <= FACE_BOTTOM; f++) begin
      if (exposed[f]) begin
        for (int k = 0; k < 6; k++) begin
          corner = CORNER_TBL[f * 6 + k];
          v.vert_x      = 5'(x + corner[5]);
          v.vert_y      = 5'(y + corner[4]);
          v.vert_z      = 5'(z + corner[3]);
          v.tex_u       = 7'(corner[2:1] * 32);
          v.tex_v       = 6'(corner[0] * 32);
          v.texture_id  = tex;
          v.last_vertex = (idx == total - 1);
          vertex_fifo = {vertex_fifo, v};
          idx++;
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    vtx_t want;
    if (!rst_ni) begin
      air_code_q   = AIR_RESET;
      dirt_code_q  = DIRT_RESET;
      grass_code_q = GRASS_RESET;
      vertex_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AIR:   air_code_q   = cfg_data_i;
          REG_DIRT:  dirt_code_q  = cfg_data_i;
          REG_GRASS: grass_code_q = cfg_data_i;
          default: ;
        endcase
      end
      // Outgoing vertices are checked before this cycle's request is predicted.
      if (vtx_i.valid && vtx_i.ready) begin
        if (vertex_fifo.size() == 0) begin
          $error("vertex with none expected: x=%0d y=%0d z=%0d tex=%0d",
                 vtx_i.data.vert_x, vtx_i.data.vert_y, vtx_i.data.vert_z,
                 vtx_i.data.texture_id);
          fails++;
        end else begin
          want = vertex_fifo.pop_front();
          compare_field("vert_x", want.vert_x, vtx_i.data.vert_x);
          compare_field("vert_y", want.vert_y, vtx_i.data.vert_y);
          compare_field("vert_z", want.vert_z, vtx_i.data.vert_z);
          compare_field("tex_u", want.tex_u, vtx_i.data.tex_u);
          compare_field("tex_v", want.tex_v, vtx_i.data.tex_v);
          compare_field("texture_id", want.texture_id, vtx_i.data.texture_id);
          compare_field("last_vertex", want.last_vertex, vtx_i.data.last_vertex);
        end
      end
      if (req_i.valid && req_i.ready &&
          req_i.data.pos_x < CHUNK_X && req_i.data.pos_y < CHUNK_Y &&
          req_i.data.pos_z < CHUNK_Z) begin
        if (req_i.data.command == CMD_WRITE) begin
          chunk_types[cell_of(req_i.data.pos_x, req_i.data.pos_y, req_i.data.pos_z)] =
            req_i.data.block_type;
        end else begin
          predict_mesh(req_i.data);
        end
      end
    end
    pending_o    <= vertex_fifo.size();
    fail_count_o <= fails;
  end

endmodule

// File: tb/tb_voxel_face_cull_mesher.sv
`timescale 1ns / 1ps

module tb_voxel_face_cull_mesher;
  import vfcm_pkg::*;

  localparam int         IDLE_LIMIT    = 4000;
  localparam int         SETTLE_CYCLES = 160;
  localparam int         TARGET_ITEMS  = 330;
  localparam int         PHASES        = 5;
  localparam int         HOLD_CYCLES   = 400;
  localparam logic [1:0] REG_SPARE     = 2'd3;

  // Code settings per phase: defaults, extremes, swapped extremes,
  // grass equal to air, defaults again without idling.
  localparam logic [0:PHASES-1][7:0] AIR_PLAN   = {8'd0, 8'd255, 8'd128, 8'd9, 8'd0};
  localparam logic [0:PHASES-1][7:0] DIRT_PLAN  = {8'd1, 8'd0, 8'd255, 8'd170, 8'd1};
  localparam logic [0:PHASES-1][7:0] GRASS_PLAN = {8'd2, 8'd254, 8'd0, 8'd9, 8'd2};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;
  int         pending;
  int         fail_count;

  vfcm_req_if req_bus ();
  vfcm_vtx_if vtx_bus ();

  bit         written [STORE_SIZE];
  logic [7:0] air_now;
  logic [7:0] dirt_now;
  logic [7:0] grass_now;
  int         sent_items;
  int         idle_cycles;
  int         sink_hold;
  bit         sender_gaps;
  bit         sink_gaps;

  voxel_face_cull_mesher DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_bus),
    .vtx_o      (vtx_bus)
  );

  vfcm_vertex_checker u_vertex_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_i        (req_bus),
    .vtx_i        (vtx_bus),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (vtx_bus.valid && vtx_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int cell_of(input int x, input int y, input int z);
    return (x * CHUNK_Y + y) * CHUNK_Z + z;
  endfunction

  // A mesh request may only read blocks that were written: itself and its neighbors.
  function automatic bit meshable(input int x, input int y, input int z);
    if (!written[cell_of(x, y, z)]) return 1'b0;
    if (x > 0 && !written[cell_of(x - 1, y, z)]) return 1'b0;
    if (x < CHUNK_X - 1 && !written[cell_of(x + 1, y, z)]) return 1'b0;
    if (y > 0 && !written[cell_of(x, y - 1, z)]) return 1'b0;
    if (y < CHUNK_Y - 1 && !written[cell_of(x, y + 1, z)]) return 1'b0;
    if (z > 0 && !written[cell_of(x, y, z - 1)]) return 1'b0;
    if (z < CHUNK_Z - 1 && !written[cell_of(x, y, z + 1)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] random_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return air_now;
    if (r < 50) return grass_now;
    if (r < 58) return dirt_now;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    vtx_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        vtx_bus.ready = 1'b0;
      end else if (sink_hold > 0) begin
        vtx_bus.ready = 1'b0;
        sink_hold = sink_hold - 1;
      end else if (stall_left > 0) begin
        vtx_bus.ready = 1'b0;
        stall_left = stall_left - 1;
      end else if (!sink_gaps || $urandom_range(0, 99) < 65) begin
        vtx_bus.ready = 1'b1;
      end else begin
        vtx_bus.ready = 1'b0;
        stall_left = gap_length() - 1;
      end
    end
  end

  // Called and returns at a falling edge. Valid stays high after the handshake;
  // the next request or a drain replaces or lowers it before the next rising edge.
  task automatic push_request(input logic cmd, input int x, input int y, input int z,
                              input logic [7:0] btype);
    req_t r;
    r.command    = cmd;
    r.pos_x      = x[3:0];
    r.pos_y      = y[3:0];
    r.pos_z      = z[3:0];
    r.block_type = btype;
    if (sender_gaps && $urandom_range(0, 99) < 30) begin
      req_bus.valid = 1'b0;
      repeat (gap_length()) @(negedge clk_i);
    end
    req_bus.valid = 1'b1;
    req_bus.data  = r;
    do @(posedge clk_i); while (!req_bus.ready);
    if (cmd == CMD_WRITE) written[cell_of(x, y, z)] = 1'b1;
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic write_block(input int x, input int y, input int z, input logic [7:0] btype);
    push_request(CMD_WRITE, x, y, z, btype);
  endtask

  task automatic mesh_block(input int x, input int y, input int z);
    push_request(CMD_MESH, x, y, z, 8'($urandom_range(0, 255)));
  endtask

  // Writes the in-chunk neighbors in the order left, right, front, back, top, bottom.
  task automatic surround(input int x, input int y, input int z, input logic [0:5][7:0] ring);
    if (x > 0) write_block(x - 1, y, z, ring[0]);
    if (x < CHUNK_X - 1) write_block(x + 1, y, z, ring[1]);
    if (z > 0) write_block(x, y, z - 1, ring[2]);
    if (z < CHUNK_Z - 1) write_block(x, y, z + 1, ring[3]);
    if (y < CHUNK_Y - 1) write_block(x, y + 1, z, ring[4]);
    if (y > 0) write_block(x, y - 1, z, ring[5]);
  endtask

  task automatic drain_and_settle();
    req_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    // Requests that give no vertices may still sit in the queue or the engine.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [7:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_AIR:   air_now   = value;
      REG_DIRT:  dirt_now  = value;
      REG_GRASS: grass_now = value;
      default: ;
    endcase
  endtask

  // Mostly a block with all its neighbors written and then meshed; the rest is
  // stray writes and meshes at random places.
  task automatic random_step();
    int              pick;
    int              x;
    int              y;
    int              z;
    int              nx;
    int              ny;
    int              nz;
    logic [0:5][7:0] ring;
    pick = $urandom_range(0, 99);
    x = $urandom_range(0, CHUNK_X - 1);
    y = $urandom_range(0, CHUNK_Y - 1);
    z = $urandom_range(0, CHUNK_Z - 1);
    if (pick < 70) begin
      for (int i = 0; i < 6; i++) ring[i] = random_type();
      surround(x, y, z, ring);
      write_block(x, y, z, random_type());
      mesh_block(x, y, z);
      if ($urandom_range(0, 99) < 30) begin
        nx = x;
        ny = y;
        nz = z;
        case ($urandom_range(0, 2))
          0: nx = x ^ 1;
          1: ny = y ^ 1;
          default: nz = z ^ 1;
        endcase
        if (meshable(nx, ny, nz)) mesh_block(nx, ny, nz);
      end
    end else if (pick < 85) begin
      write_block(x, y, z, 8'($urandom_range(0, 255)));
    end else if (meshable(x, y, z)) begin
      mesh_block(x, y, z);
    end
  endtask

  initial begin : stimulus
    int base_items;
    int phase_end;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_AIR;
    cfg_data      = '0;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    sender_gaps   = 1'b0;
    sink_gaps     = 1'b0;
    sink_hold     = 0;
    sent_items    = 0;
    idle_cycles   = 0;
    air_now       = AIR_RESET;
    dirt_now      = DIRT_RESET;
    grass_now     = GRASS_RESET;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Origin corner: grass under a solid block turns to dirt, three border faces.
    surround(0, 0, 0, {air_now, air_now, air_now, 8'd255, 8'd9, air_now});
    write_block(0, 0, 0, grass_now);
    mesh_block(0, 0, 0);
    // Far corner: grass in the top layer keeps its own texture.
    surround(CHUNK_X - 1, CHUNK_Y - 1, CHUNK_Z - 1,
             {grass_now, air_now, air_now, air_now, air_now, air_now});
    write_block(CHUNK_X - 1, CHUNK_Y - 1, CHUNK_Z - 1, grass_now);
    mesh_block(CHUNK_X - 1, CHUNK_Y - 1, CHUNK_Z - 1);
    // Floating block: air gives nothing, then all six faces.
    surround(8, 7, 6, {6{air_now}});
    write_block(8, 7, 6, air_now);
    mesh_block(8, 7, 6);
    write_block(8, 7, 6, 8'd255);
    mesh_block(8, 7, 6);
    // Same block buried on every side gives nothing.
    surround(8, 7, 6, {6{8'd200}});
    mesh_block(8, 7, 6);
    drain_and_settle();

    base_items = sent_items;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) set_register(REG_SPARE, 8'hA5);
      set_register(REG_AIR, AIR_PLAN[phase]);
      set_register(REG_DIRT, DIRT_PLAN[phase]);
      set_register(REG_GRASS, GRASS_PLAN[phase]);
      sender_gaps = (phase != PHASES - 1);
      sink_gaps   = (phase != PHASES - 1);
      // The receiver holds off while requests keep coming, so the input backs up.
      if (phase == 0) sink_hold = HOLD_CYCLES;
      phase_end = base_items + (phase + 1) * (TARGET_ITEMS - base_items) / PHASES;
      while (sent_items < phase_end) random_step();
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
